// ===== src/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULT,
		S_SUM,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mult;
		logic sum;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic div_sel_den;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} stat_t;
endpackage
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
`default_nettype none
// rational_arithmetic_unit: combines two signed fractions a_num/a_den and
// b_num/b_den by add, subtract, multiply or divide and returns the result
// reduced to lowest terms with a positive denominator (zero reads 0/1)
// input channel s_axis_*: tdata carries opcode, a_num, a_den, b_num, b_den
// output channel m_axis_*: tdata carries res_num, res_den, status
// one item is worked on at a time; s_axis_tready is high only when idle
// the steps are multiply, sum, then the euclid loop where every remainder
// comes from a shift-subtract unit, then two quotients from the same unit;
// error items go from the sum state straight to done and show a zero result
// the next item is taken the cycle after a result is written
// the result sits in an output register and the controller goes back to idle;
// a stalled receiver holds that result, and the following item then waits
// in the done state until m_axis_tready, with s_axis_tready low meanwhile
// reset (arst_n low) returns the controller to idle with no result pending
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// opcode, a_num, a_den, b_num, b_den, zero pad
	input  wire logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// res_num, res_den, status
	output logic [71:0]                     m_axis_tdata
);
	localparam int W = OPERAND_WIDTH;
	cmd_t  cmd;
	stat_t st;
	logic  busy;
	logic  vld_q;
	logic signed [NUM_W-1:0] res_num;
	logic [DEN_W-1:0] res_den;
	logic [1:0] status;

	assign s_axis_tready = !busy;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {6'd0, status, res_den, res_num};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (cmd.finish) vld_q <= 1'b1;
		else if (m_axis_tready) vld_q <= 1'b0;
	end

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_free(!vld_q || m_axis_tready),
		.st(st), .cmd(cmd), .busy(busy)
	);

	rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.op_in(s_axis_tdata[1:0]),
		.an_in(s_axis_tdata[2+W-1:2]),
		.ad_in(s_axis_tdata[2+2*W-1:2+W]),
		.bn_in(s_axis_tdata[2+3*W-1:2+2*W]),
		.bd_in(s_axis_tdata[2+4*W-1:2+3*W]),
		.st(st), .res_num(res_num), .res_den(res_den), .status(status)
	);
endmodule
`default_nettype wire

// ===== src/rau_ctrl.sv =====
`default_nettype none
module rau_ctrl import rau_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_fire,
	input  wire logic  out_free,
	input  wire stat_t st,
	output cmd_t       cmd,
	output logic       busy
);
	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.load = 1'b1;
					nxt = S_MULT;
				end
			end
			S_MULT: begin
				cmd.mult = 1'b1;
				nxt = S_SUM;
			end
			S_SUM: begin
				if (st.early) nxt = S_DONE;
				else begin
					cmd.sum = 1'b1;
					nxt = S_GCD;
				end
			end
			S_GCD: begin
				if (st.gcd_done) begin
					cmd.div_start = 1'b1;
					nxt = S_DIVN;
				end else cmd.gcd_step = 1'b1;
			end
			S_DIVN: begin
				if (st.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel_den = 1'b1;
					nxt = S_DIVD;
				end else cmd.div_step = 1'b1;
			end
			S_DIVD: begin
				cmd.div_sel_den = 1'b1;
				if (st.div_done) nxt = S_DONE;
				else cmd.div_step = 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/rau_dp.sv =====
`default_nettype none
module rau_dp import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cmd_t                            cmd,
	input  wire logic [1:0]                      op_in,
	input  wire logic signed [OPERAND_WIDTH-1:0] an_in,
	input  wire logic signed [OPERAND_WIDTH-1:0] ad_in,
	input  wire logic signed [OPERAND_WIDTH-1:0] bn_in,
	input  wire logic signed [OPERAND_WIDTH-1:0] bd_in,
	output stat_t                                st,
	output logic signed [NUM_W-1:0]              res_num,
	output logic        [DEN_W-1:0]              res_den,
	output logic        [1:0]                    status
);
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int SW = PW + 1;
	localparam int MW = PW + 1;
	localparam int CW = $clog2(MW + 1);

	logic [1:0] op_q;
	logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [PW-1:0] p1_q, p2_q, pd_q;
	logic [1:0] err_q;
	logic [MW-1:0] un_q, ud_q, gx_q, gy_q;
	logic neg_q;
	logic [MW-1:0] quo_q, rem_q, dvd_q;
	logic [CW-1:0] cnt_q;
	logic signed [SW-1:0] n_w;
	logic signed [SW-1:0] d_w;
	logic [MW-1:0] rem_nx, gx_rem;
	logic [MW:0] trial;

	// euclid step uses a serial divider too: gcd via repeated subtraction-free
	// remainder is long, so a binary-style shift-subtract remainder is used
	logic gdiv_active_q;

	always_comb begin
		case (op_q)
			OP_ADD: n_w = SW'(p1_q) + SW'(p2_q);
			OP_SUB: n_w = SW'(p1_q) - SW'(p2_q);
			default: n_w = SW'(p1_q);
		endcase
		d_w = SW'(pd_q);
	end

	assign st.early = err_q != ST_OK;
	assign st.gcd_done = (gy_q == '0) && !gdiv_active_q;
	assign st.div_done = cnt_q == '0;

	assign trial = {rem_q, dvd_q[MW-1]} - {1'b0, gx_q};
	assign rem_nx = trial[MW] ? {rem_q[MW-2:0], dvd_q[MW-1]} : trial[MW-1:0];
	assign gx_rem = rem_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gdiv_active_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd.sum) begin
				gdiv_active_q <= 1'b0;
				cnt_q <= '0;
			end else if (cmd.gcd_step) begin
				if (!gdiv_active_q) begin
					gdiv_active_q <= 1'b1;
					cnt_q <= CW'(MW);
				end else if (cnt_q == CW'(1)) begin
					gdiv_active_q <= 1'b0;
					cnt_q <= '0;
				end else cnt_q <= cnt_q - 1'b1;
			end else if (cmd.div_start) begin
				cnt_q <= CW'(MW);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_in;
			an_q <= an_in;
			ad_q <= ad_in;
			bn_q <= bn_in;
			bd_q <= bd_in;
			if (ad_in == '0 || bd_in == '0) err_q <= ST_ZERO_DEN;
			else if (op_in == OP_DIV && bn_in == '0) err_q <= ST_DIV_ZERO;
			else err_q <= ST_OK;
		end
		// operands sign-extended before the multiply so the products are exact
		if (cmd.mult) begin
			case (op_q)
				OP_MUL: begin
					p1_q <= PW'(an_q) * PW'(bn_q);
					p2_q <= '0;
					pd_q <= PW'(ad_q) * PW'(bd_q);
				end
				OP_DIV: begin
					p1_q <= PW'(an_q) * PW'(bd_q);
					p2_q <= '0;
					pd_q <= PW'(ad_q) * PW'(bn_q);
				end
				default: begin
					p1_q <= PW'(an_q) * PW'(bd_q);
					p2_q <= PW'(bn_q) * PW'(ad_q);
					pd_q <= PW'(ad_q) * PW'(bd_q);
				end
			endcase
		end
		if (cmd.sum) begin
			un_q <= n_w[SW-1] ? MW'(-n_w) : MW'(n_w);
			ud_q <= d_w[SW-1] ? MW'(-d_w) : MW'(d_w);
			gx_q <= n_w[SW-1] ? MW'(-n_w) : MW'(n_w);
			gy_q <= d_w[SW-1] ? MW'(-d_w) : MW'(d_w);
			neg_q <= n_w[SW-1] != d_w[SW-1];
		end
		// gcd: x % y computed by shift-subtract, divisor y moved into gx, remainder into gy
		if (cmd.gcd_step) begin
			if (!gdiv_active_q) begin
				rem_q <= '0;
				dvd_q <= gx_q;
				gx_q <= gy_q;
			end else begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[MW-2:0], 1'b0};
				if (cnt_q == CW'(1)) gy_q <= gx_rem;
			end
		end
		if (cmd.div_start) begin
			if (!cmd.div_sel_den) begin
				gx_q <= (gx_q == '0) ? MW'(1) : gx_q;
				dvd_q <= un_q;
			end else begin
				un_q <= quo_q;
				dvd_q <= ud_q;
			end
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[MW-2:0], 1'b0};
			quo_q <= {quo_q[MW-2:0], ~trial[MW]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= err_q;
			if (err_q != ST_OK) begin
				res_num <= '0;
				res_den <= '0;
			end else if (un_q == '0) begin
				res_num <= '0;
				res_den <= DEN_W'(1);
			end else begin
				res_num <= neg_q ? -NUM_W'(un_q) : NUM_W'(un_q);
				res_den <= DEN_W'(quo_q);
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/rau_checker.sv =====
`default_nettype none
module rau_checker import rau_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [71:0] m_axis_tdata
);
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata)) else $error("unknown result data");
	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[65:64] <= ST_DIV_ZERO) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[65:64] != ST_OK |-> m_axis_tdata[63:0] == 64'd0)
		else $error("error item with data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== tb/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int OW = OPERAND_WIDTH_DEF;
	localparam int IN_W = ((4*OW+2+7)/8)*8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic signed [OW-1:0] b_den;
		logic signed [OW-1:0] b_num;
		logic signed [OW-1:0] a_den;
		logic signed [OW-1:0] a_num;
		opcode_t opcode;
	} frac_op_t;

	typedef struct packed {
		status_t status;
		logic [DEN_W-1:0] res_den;
		logic signed [NUM_W-1:0] res_num;
	} frac_res_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [71:0] m_axis_tdata;

	frac_op_t pending_ops[$];
	frac_res_t expected_fracs[$];
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;
	int idle_cycles;
	int errors;
	bit hold_req;
	bit hold_taken;

	rational_arithmetic_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic longint unsigned gcd_u(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// exact fraction result in lowest terms
	function automatic frac_res_t reduce_frac(frac_op_t op);
		frac_res_t r;
		longint n, d;
		longint unsigned un, ud, g;
		bit neg;
		longint an, ad, bn, bd;
		an = longint'(op.a_num); ad = longint'(op.a_den);
		bn = longint'(op.b_num); bd = longint'(op.b_den);
		r = '0;
		if (ad == 0 || bd == 0) begin
			r.status = ST_ZERO_DEN;
			return r;
		end
		if (op.opcode == OP_DIV && bn == 0) begin
			r.status = ST_DIV_ZERO;
			return r;
		end
		case (op.opcode)
			OP_ADD: begin n = an*bd + bn*ad; d = ad*bd; end
			OP_SUB: begin n = an*bd - bn*ad; d = ad*bd; end
			OP_MUL: begin n = an*bn; d = ad*bd; end
			default: begin n = an*bd; d = ad*bn; end
		endcase
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		neg = (n < 0) != (d < 0);
		g = gcd_u(un, ud);
		if (g == 0) g = 1;
		un = un / g;
		ud = ud / g;
		if (un == 0) begin
			ud = 1;
			neg = 0;
		end
		r.res_num = NUM_W'(neg ? -un : un);
		r.res_den = DEN_W'(ud);
		r.status = ST_OK;
		return r;
	endfunction

	function automatic logic [OW-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			1: return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
			2: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return OW'($urandom);
		endcase
	endfunction

	task automatic push_op(opcode_t oc, int an, int ad, int bn, int bd);
		frac_op_t op;
		op.opcode = oc;
		op.a_num = OW'(an); op.a_den = OW'(ad); op.b_num = OW'(bn); op.b_den = OW'(bd);
		pending_ops.push_back(op);
	endtask

	task automatic push_random(int count);
		frac_op_t op;
		repeat (count) begin
			op.opcode = opcode_t'($urandom_range(0, 3));
			op.a_num = rand_operand();
			op.b_num = rand_operand();
			op.a_den = rand_operand();
			op.b_den = rand_operand();
			// keep zero denominators rare
			if ($urandom_range(0, 19) == 0) op.a_den = 0;
			else if (op.a_den == 0) op.a_den = 1;
			if ($urandom_range(0, 19) == 0) op.b_den = 0;
			else if (op.b_den == 0) op.b_den = 1;
			pending_ops.push_back(op);
		end
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || expected_fracs.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with no handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// driver: keeps valid up until handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				expected_fracs.push_back(reduce_frac(frac_op_t'(s_axis_tdata[4*OW+1:0])));
				void'(pending_ops.pop_front());
			end
			if (pending_ops.size() > 0 &&
			    $urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= IN_W'(pending_ops[0]);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compare against oldest expected result
	always @(posedge clk) begin
		frac_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[NUM_W+DEN_W+1:0];
			if (expected_fracs.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
			end else begin
				want = expected_fracs.pop_front();
				if (got.res_num !== want.res_num) begin
					$error("res_num expected %0d got %0d", want.res_num, got.res_num);
					errors++;
				end
				if (got.res_den !== want.res_den) begin
					$error("res_den expected %0d got %0d", want.res_den, got.res_den);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, got.status);
					errors++;
				end
			end
		end
	end

	// receiver ready, with one long hold-off counted here once requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_off <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every op, extremes, zero denominators, zero divisor, zero result
		push_op(OP_ADD, 1, 2, 1, 3);
		push_op(OP_SUB, 1, 2, 1, 2);
		push_op(OP_MUL, -32768, -32768, -32768, -32768);
		push_op(OP_DIV, 32767, -32768, -32768, 32767);
		push_op(OP_ADD, 32767, 1, 32767, 1);
		push_op(OP_SUB, -32768, 1, 32767, 1);
		push_op(OP_MUL, -32768, 1, -32768, 1);
		push_op(OP_DIV, -32768, 1, 1, 32767);
		push_op(OP_ADD, 3, 0, 1, 1);
		push_op(OP_DIV, 1, 1, 0, 0);
		push_op(OP_DIV, 5, 7, 0, 3);
		push_op(OP_MUL, 0, -5, 7, 9);
		push_op(OP_ADD, 6, -4, -9, 6);
		push_op(OP_DIV, -1, -1, -1, -1);
		push_op(OP_SUB, 0, 1, 0, -1);
		push_op(OP_MUL, 12, 18, -30, 45);
		push_op(OP_ADD, 1, 32767, 1, -32768);
		drain();

		send_idle_pct = 0; recv_stall_pct = 0;
		push_random(130); drain();
		send_idle_pct = 71; recv_stall_pct = 0;
		push_random(120); drain();
		send_idle_pct = 0; recv_stall_pct = 71;
		push_random(120); drain();
		send_idle_pct = 18; recv_stall_pct = 18;
		push_random(120); drain();

		// long receiver hold-off while input keeps offering
		send_idle_pct = 0; recv_stall_pct = 0;
		push_random(140);
		hold_req = 1'b1;
		drain();

		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
